/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the channeliser RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hdl/pcm_pkg.sv */
// ---------------------------------------------------------------------------
// pcm_pkg
// Types, constants and twiddle table for the polyphase channeliser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package pcm_pkg;

    typedef struct packed {
        logic               func;
        logic signed [15:0] sample;
        logic        [9:0]  coef_index;
        logic signed [15:0] coef_value;
    } t_in_item;

    typedef struct packed {
        logic [5:0]  channel;
        logic [23:0] magnitude;
        logic        last;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE, S_SHIFT_RD, S_SHIFT_WR, S_FIR, S_FIR_END,
        S_DFT, S_DFT_END, S_ROUND, S_SQRT, S_EMIT, S_CLEAR
    } t_state;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;
    localparam logic [23:0] MAG_MAX = 24'hFFFFFF;

    function automatic logic signed [15:0] quarter_cos(input logic [4:0] r);
        logic signed [15:0] v;
        case (r)
            5'd0:  v = 16'sd16384;
            5'd1:  v = 16'sd16305;
            5'd2:  v = 16'sd16069;
            5'd3:  v = 16'sd15679;
            5'd4:  v = 16'sd15137;
            5'd5:  v = 16'sd14449;
            5'd6:  v = 16'sd13623;
            5'd7:  v = 16'sd12665;
            5'd8:  v = 16'sd11585;
            5'd9:  v = 16'sd10394;
            5'd10: v = 16'sd9102;
            5'd11: v = 16'sd7723;
            5'd12: v = 16'sd6270;
            5'd13: v = 16'sd4756;
            5'd14: v = 16'sd3196;
            5'd15: v = 16'sd1606;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    // Cosine of 2*pi*i/64 in Q2.14.
    function automatic logic signed [15:0] cos64(input logic [5:0] i);
        logic [1:0] q;
        logic [4:0] r;
        logic signed [15:0] v;
        q = i[5:4];
        r = {1'b0, i[3:0]};
        case (q)
            2'd0: v = quarter_cos(r);
            2'd1: v = -quarter_cos(5'd16 - r);
            2'd2: v = -quarter_cos(r);
            default: v = quarter_cos(5'd16 - r);
        endcase
        return v;
    endfunction

endpackage

/* hdl/pcm_ram.sv */
// ---------------------------------------------------------------------------
// pcm_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hdl/polyphase_channelizer_magnitude.sv */
// Input: a coefficient item is written in its accepting cycle; a sample item then stalls the
// input while it is shifted into its branch's delay line. A block-completing sample goes on
// to the branch FIRs and raises one magnitude per channel, each after its DFT, rounding and root.
// Throughput: one item at a time; the input stays stalled until the last magnitude is issued.
// Reset: synchronous, active low; after it a clearing pass zeroes the delay-line and
// coefficient RAMs, during which no item is accepted.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ---------------------------------------------------------------------------
// Polyphase channeliser with subband magnitudes
// Branch FIRs over RAM-held delay lines, a sequential DFT and a bit-serial root.
// ---------------------------------------------------------------------------
module polyphase_channelizer_magnitude #(
    parameter int CHANNELS = 8,
    parameter int TAPS     = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  pcm_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output pcm_pkg::t_out_item  o_item
);
    import pcm_pkg::*;

    // Memories hold CHANNELS*TAPS words each, addressed branch*TAPS + slot.
    localparam int DEPTH = CHANNELS * TAPS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(CHANNELS);
    localparam int TW    = (TAPS > 1) ? $clog2(TAPS) : 1;
    // A coefficient position is split into branch and tap by a reciprocal multiply,
    // which is exact for every ten-bit index.
    localparam int RECIP_SH = 20;
    localparam int RECIP    = ((1 << RECIP_SH) + CHANNELS - 1) / CHANNELS;

    // Twiddle index (ph * 64) / CHANNELS for every phase, six bits per entry.
    function automatic logic [383:0] ph_table();
        logic [383:0] t;
        t = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            t[i*6 +: 6] = 6'((i * 64) / CHANNELS);
        end
        return t;
    endfunction

    localparam logic [383:0] PH_LUT = ph_table();

    t_state r_state, n_state;

    // Delay-line and coefficient memories.
    logic          dl_we, cf_we;
    logic [AW-1:0] dl_waddr, dl_raddr, cf_waddr, cf_raddr;
    logic [15:0]   dl_wdata, cf_wdata, dl_rdata, cf_rdata;

    pcm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_dl (
        .i_clk(i_clk), .i_we(dl_we), .i_waddr(dl_waddr), .i_wdata(dl_wdata),
        .i_raddr(dl_raddr), .o_rdata(dl_rdata));
    pcm_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_cf (
        .i_clk(i_clk), .i_we(cf_we), .i_waddr(cf_waddr), .i_wdata(cf_wdata),
        .i_raddr(cf_raddr), .o_rdata(cf_rdata));

    // Branch outputs: CHANNELS words, written by the FIR and read in turn by the DFT for every channel.
    logic          y_we;
    logic [CW-1:0] y_waddr, y_raddr;
    logic [35:0]   y_wdata, y_rdata;
    pcm_ram #(.WIDTH(36), .DEPTH(CHANNELS)) u_y (
        .i_clk(i_clk), .i_we(y_we), .i_waddr(y_waddr), .i_wdata(y_wdata),
        .i_raddr(y_raddr), .o_rdata(y_rdata));

    logic [CW-1:0]  r_ptr, n_ptr;       // branch for next sample
    logic [AW:0]    r_cnt, n_cnt;       // general counter
    logic [TW:0]    r_tap, n_tap;
    logic [CW:0]    r_br, n_br;
    logic [CW:0]    r_k, n_k;
    logic signed [15:0] r_hold, n_hold; // word carried down the shift
    logic signed [35:0] r_acc, n_acc;
    logic signed [63:0] r_re, n_re, r_im, n_im;
    logic [CW-1:0]  r_ph, n_ph;         // m*k mod CHANNELS
    logic           r_pv, n_pv;         // twiddle and branch read in flight
    logic           r_pv2;              // products ready to accumulate
    logic signed [15:0] r_p0, n_p0, r_p1, n_p1;
    logic [36:0]    r_rr, n_rr, r_ri, n_ri;
    logic [49:0]    r_sq, n_sq;         // radicand
    logic [24:0]    r_root, n_root;
    logic [25:0]    r_rem, n_rem;
    logic [4:0]     r_it, n_it;
    logic           r_ovf, n_ovf;
    logic           r_ov, n_ov;
    t_out_item      r_out, n_out;
    logic signed [15:0] r_tc, n_tc, r_ts, n_ts;
    logic signed [35:0] r_y, n_y;

    logic signed [31:0] fir_prod;
    logic signed [51:0] mac_re, mac_im;
    logic [63:0] abs_re, abs_im;
    logic [36:0] rr, ri;
    logic [47:0] sq_re, sq_im;
    logic [27:0] sqrt_cand;
    logic [28:0] trial;
    logic [5:0]  ph64;
    logic [CW:0] ph_sum;
    logic [29:0] cidx_prod;
    logic [9:0]  cidx_q, cidx_r;

    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign o_stall = (r_state != S_IDLE);
    assign fir_prod = $signed(cf_rdata) * $signed(dl_rdata);
    assign mac_re = 52'(r_y) * 52'(r_p0);
    assign mac_im = 52'(r_y) * 52'(r_p1);
    assign ph64 = PH_LUT[32'(r_ph) * 6 +: 6];
    assign ph_sum = (CW+1)'(r_ph) + r_k;
    assign abs_re = r_re[63] ? 64'(-r_re) : 64'(r_re);
    assign abs_im = r_im[63] ? 64'(-r_im) : 64'(r_im);
    assign rr = 37'((abs_re + (64'd1 << 26)) >> 27);
    assign ri = 37'((abs_im + (64'd1 << 26)) >> 27);
    assign sq_re = 48'(r_rr[23:0]) * 48'(r_rr[23:0]);
    assign sq_im = 48'(r_ri[23:0]) * 48'(r_ri[23:0]);
    assign sqrt_cand = {r_rem, r_sq[49:48]};
    assign trial = {1'b0, sqrt_cand} - {2'b00, r_root, 2'b01};
    assign cidx_prod = 30'(i_item.coef_index) * 30'(RECIP);
    assign cidx_q = cidx_prod[RECIP_SH +: 10];
    assign cidx_r = i_item.coef_index - 10'(32'(cidx_q) * CHANNELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_ptr   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
            r_pv    <= n_pv;
        end
        r_tap <= n_tap; r_br <= n_br; r_k <= n_k; r_hold <= n_hold; r_acc <= n_acc;
        r_re <= n_re; r_im <= n_im; r_ph <= n_ph; r_p0 <= n_p0; r_rr <= n_rr;
        r_p1 <= n_p1; r_sq <= n_sq; r_root <= n_root; r_rem <= n_rem; r_it <= n_it;
        r_ovf <= n_ovf; r_out <= n_out; r_tc <= n_tc; r_ts <= n_ts; r_y <= n_y;
        r_ri <= n_ri;
    end

    always_comb begin
        n_state = r_state; n_ptr = r_ptr; n_cnt = r_cnt; n_tap = r_tap; n_br = r_br;
        n_k = r_k; n_hold = r_hold; n_acc = r_acc; n_re = r_re; n_im = r_im;
        n_ph = r_ph; n_pv = 1'b0; n_p0 = r_p0; n_p1 = r_p1; n_rr = r_rr; n_ri = r_ri;
        n_sq = r_sq; n_root = r_root; n_rem = r_rem; n_it = r_it; n_ovf = r_ovf;
        n_ov = r_ov; n_out = r_out; n_tc = r_tc; n_ts = r_ts; n_y = r_y;
        dl_we = 1'b0; dl_waddr = '0; dl_wdata = '0; dl_raddr = '0;
        cf_we = 1'b0; cf_waddr = '0; cf_wdata = '0; cf_raddr = '0;
        y_we = 1'b0; y_waddr = '0; y_wdata = '0; y_raddr = '0;
        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                dl_we = 1'b1; cf_we = 1'b1;
                dl_waddr = AW'(r_cnt); cf_waddr = AW'(r_cnt);
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.func == FUNC_COEF) begin
                        // Branch is the index modulo CHANNELS; the tap slot runs reversed.
                        if (32'(i_item.coef_index) < DEPTH) begin
                            cf_we = 1'b1;
                            cf_wdata = i_item.coef_value;
                            cf_waddr = AW'(32'(cidx_r) * TAPS + (TAPS - 1 - 32'(cidx_q)));
                        end
                    end else begin
                        n_hold = i_item.sample;
                        n_tap = '0;
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_SHIFT_RD: begin
                // read the slot about to be overwritten
                dl_raddr = AW'(32'(r_ptr) * TAPS + 32'(r_tap));
                n_state = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                dl_we = 1'b1;
                dl_waddr = AW'(32'(r_ptr) * TAPS + 32'(r_tap));
                dl_wdata = r_hold;
                n_hold = dl_rdata;
                n_tap = r_tap + 1'b1;
                if (32'(r_tap) == TAPS - 1) begin
                    if (32'(r_ptr) == CHANNELS - 1) begin
                        n_ptr = '0;
                        n_cnt = '0;
                        n_tap = '0;
                        n_br = '0;
                        n_acc = '0;
                        n_state = S_FIR;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_FIR: begin
                // Read word r_cnt and accumulate the previous word's product. r_tap and
                // r_br track the slot and branch of r_cnt; slot zero closes a branch.
                dl_raddr = AW'(r_cnt);
                cf_raddr = AW'(r_cnt);
                if (r_cnt != '0) begin
                    n_acc = r_acc + 36'(fir_prod);
                    if (r_tap == '0) begin
                        y_we = 1'b1;
                        y_waddr = CW'(r_br - 1'b1);
                        y_wdata = n_acc;
                        n_acc = '0;
                    end
                end
                if (32'(r_tap) == TAPS - 1) begin
                    n_tap = '0;
                    n_br = r_br + 1'b1;
                end else begin
                    n_tap = r_tap + 1'b1;
                end
                n_cnt = r_cnt + 1'b1;
                if (32'(r_cnt) == DEPTH - 1) begin
                    n_state = S_FIR_END;
                end
            end
            S_FIR_END: begin
                y_we = 1'b1;
                y_waddr = CW'(CHANNELS - 1);
                y_wdata = r_acc + 36'(fir_prod);
                n_k = '0;
                n_br = '0;
                n_ph = '0;
                n_re = '0;
                n_im = '0;
                n_state = S_DFT;
            end
            S_DFT: begin
                // stage 1: read y[m] and twiddle; stage 2: register operands; stage 3: MAC
                y_raddr = CW'(r_br);
                n_tc = cos64(ph64);
                n_ts = cos64(ph64 + 6'd48);
                n_pv = 1'b1;
                n_br = r_br + 1'b1;
                n_ph = (32'(ph_sum) >= CHANNELS) ? CW'(32'(ph_sum) - CHANNELS)
                                                 : CW'(ph_sum);
                if (32'(r_br) == CHANNELS - 1) begin
                    n_state = S_DFT_END;
                    n_cnt = '0;
                end
            end
            S_DFT_END: begin
                // Wait until the last product has passed the operand and accumulate stages; then round both sums.
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (AW+1)'(2)) begin
                    n_rr = rr;
                    n_ri = ri;
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                // Either component at 2^24 or above already saturates the magnitude.
                n_sq = 50'(sq_re) + 50'(sq_im);
                n_ovf = (r_rr >= 37'd16777216) || (r_ri >= 37'd16777216);
                n_root = '0;
                n_rem = '0;
                n_it = '0;
                n_state = S_SQRT;
            end
            S_SQRT: begin
                // One result bit per cycle, two radicand bits consumed each time.
                if (!trial[28]) begin
                    n_rem = trial[25:0];
                    n_root = {r_root[23:0], 1'b1};
                end else begin
                    n_rem = sqrt_cand[25:0];
                    n_root = {r_root[23:0], 1'b0};
                end
                n_sq = {r_sq[47:0], 2'b00};
                n_it = r_it + 1'b1;
                if (r_it == 5'd24) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_out.channel = 6'(r_k);
                    n_out.magnitude = (r_ovf || r_root[24]) ? MAG_MAX : r_root[23:0];
                    n_out.last = (32'(r_k) == CHANNELS - 1);
                    if (32'(r_k) == CHANNELS - 1) begin
                        n_state = S_IDLE;
                    end else begin
                        n_k = r_k + 1'b1;
                        n_br = '0;
                        n_ph = '0;
                        n_re = '0;
                        n_im = '0;
                        n_state = S_DFT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
        // Multiply-accumulate pipeline running behind the DFT sequencer.
        if (r_pv) begin
            n_y = $signed(y_rdata);
            n_p0 = r_tc;
            n_p1 = r_ts;
        end
        if (r_pv2) begin
            n_re = r_re + 64'(mac_re);
            n_im = r_im - 64'(mac_im);
        end
    end

    // r_pv2 is r_pv registered, so the accumulate stage runs in the cycle after the operand stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv2 <= 1'b0;
        end else begin
            r_pv2 <= r_pv;
        end
    end

    `ASSERT_IMPL(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n,
        r_state == S_EMIT && !r_ov && 32'(r_k) == CHANNELS - 1, r_state == S_IDLE)
    `ASSERT_IMPL(a_ptr_range, i_clk, i_rst_n, 1'b1, 32'(r_ptr) < CHANNELS)
endmodule

/* tb/polyphase_channelizer_magnitude_tb.sv */
// ---------------------------------------------------------------------------
// Polyphase channeliser magnitude testbench
// Drives sample and coefficient items with random gaps and output stalls,
// predicts every subband magnitude in the bench and compares each result
// as a whole item (channel, magnitude, last), in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class subband_scoreboard;
    localparam int NCH = 8;
    localparam int NTAP = 4;

    logic signed [15:0] delay_line [NCH][NTAP];
    logic signed [15:0] coef_slot [NCH][NTAP];
    int unsigned next_branch;
    pcm_pkg::t_out_item pending[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned blocks_seen;
    int unsigned coef_writes;

    function new();
        for (int m = 0; m < NCH; m++) begin
            for (int t = 0; t < NTAP; t++) begin
                delay_line[m][t] = '0;
                coef_slot[m][t] = '0;
            end
        end
        next_branch = 0;
        mismatches = 0;
        results_seen = 0;
        blocks_seen = 0;
        coef_writes = 0;
    endfunction

    // Q2.14 cosine of 2*pi*i/64, built from a quarter-wave table.
    function automatic longint twiddle_cos(int unsigned i);
        longint qc [17];
        int unsigned q;
        int unsigned r;
        qc = '{16384, 16305, 16069, 15679, 15137, 14449, 13623, 12665, 11585,
               10394, 9102, 7723, 6270, 4756, 3196, 1606, 0};
        q = (i >> 4) & 3;
        r = i & 15;
        case (q)
            0: return qc[r];
            1: return -qc[16 - r];
            2: return -qc[r];
            default: return qc[16 - r];
        endcase
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned round_q15(longint acc);
        longint unsigned a;
        a = (acc < 0) ? longint'(-acc) : acc;
        return (a + (64'd1 << 26)) >> 27;
    endfunction

    function void note_input(pcm_pkg::t_in_item it);
        longint y [NCH];
        longint re;
        longint im;
        longint unsigned rr;
        longint unsigned ii;
        longint unsigned mag;
        int unsigned ph;
        pcm_pkg::t_out_item r;
        if (it.func == pcm_pkg::FUNC_COEF) begin
            if (it.coef_index < NCH * NTAP) begin
                coef_slot[it.coef_index % NCH][NTAP - 1 - it.coef_index / NCH] = it.coef_value;
                coef_writes++;
            end
            return;
        end
        for (int t = NTAP - 1; t > 0; t--)
            delay_line[next_branch][t] = delay_line[next_branch][t - 1];
        delay_line[next_branch][0] = it.sample;
        next_branch++;
        if (next_branch < NCH) return;
        next_branch = 0;
        for (int m = 0; m < NCH; m++) begin
            y[m] = 0;
            for (int t = 0; t < NTAP; t++)
                y[m] += longint'(coef_slot[m][t]) * longint'(delay_line[m][t]);
        end
        for (int k = 0; k < NCH; k++) begin
            re = 0;
            im = 0;
            for (int m = 0; m < NCH; m++) begin
                ph = ((m * k) % NCH) * 64 / NCH;
                re += y[m] * twiddle_cos(ph);
                im -= y[m] * twiddle_cos(ph + 48);
            end
            rr = round_q15(re);
            ii = round_q15(im);
            mag = root_floor(rr * rr + ii * ii);
            if (mag > pcm_pkg::MAG_MAX) mag = pcm_pkg::MAG_MAX;
            r.channel = k[5:0];
            r.magnitude = mag[23:0];
            r.last = (k == NCH - 1);
            pending.push_back(r);
        end
    endfunction

    function void check_result(pcm_pkg::t_out_item got);
        pcm_pkg::t_out_item exp_item;
        results_seen++;
        if (got.last) blocks_seen++;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result: %p", got);
            return;
        end
        exp_item = pending.pop_front();
        if (got !== exp_item) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch: expected ch %0d mag %0d last %0d, got ch %0d mag %0d last %0d",
                         exp_item.channel, exp_item.magnitude, exp_item.last,
                         got.channel, got.magnitude, got.last);
        end
    endfunction
endclass

module polyphase_channelizer_magnitude_tb;
    import pcm_pkg::*;

    localparam int NCH = 8;
    localparam int NTAP = 4;
    // Cycle allowance for one block, with margin.
    localparam int BLOCK_CYCLES = 2 * NCH * NTAP + NCH * (NCH + 40);

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in_item i_item;
    logic o_valid;
    logic i_stall;
    t_out_item o_item;

    subband_scoreboard sb;
    t_in_item stimulus[$];
    bit stimulus_done;
    // When set, the receiver stalls solidly so that the block backs up.
    bit hold_output;

    polyphase_channelizer_magnitude #(.CHANNELS(NCH), .TAPS(NTAP)) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Generous watchdog: fails the run if it never finishes.
    initial begin
        #(20ns * 2000000);
        $display("Verification failed");
        $finish;
    end

    // Helpers that build items for the sender's queue.
    function automatic t_in_item sample_item(logic signed [15:0] s);
        t_in_item it;
        it = '0;
        it.func = FUNC_SAMPLE;
        it.sample = s;
        // Unused fields carry noise so that they are seen to be ignored.
        it.coef_index = 10'($urandom);
        it.coef_value = 16'($urandom);
        return it;
    endfunction

    function automatic t_in_item coef_item(logic [9:0] idx, logic signed [15:0] v);
        t_in_item it;
        it.func = FUNC_COEF;
        it.sample = 16'($urandom);
        it.coef_index = idx;
        it.coef_value = v;
        return it;
    endfunction

    task automatic build_stimulus();
        // Directed part: taps at both full-scale extremes, extreme samples,
        // out-of-range indices and a sample that completes no block.
        stimulus.push_back(coef_item(10'd0, 16'sh7FFF));
        stimulus.push_back(coef_item(10'd1023, 16'sh1234));
        stimulus.push_back(coef_item(10'(NCH * NTAP), 16'sh4321));
        stimulus.push_back(coef_item(10'(NCH * NTAP - 1), -16'sd32768));
        for (int i = 0; i < NCH; i++)
            stimulus.push_back(sample_item(i[0] ? -16'sd32768 : 16'sh7FFF));
        for (int i = 0; i < NCH; i++)
            stimulus.push_back(coef_item(10'(i), (i % 2) ? -16'sd32768 : 16'sh7FFF));
        stimulus.push_back(sample_item(16'sh7FFF));
        // Random part: runs of coefficient writes, some out of range, and whole sample blocks.
        while (stimulus.size() < 150) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 12))
                    stimulus.push_back(coef_item(
                        ($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                    : 10'($urandom_range(0, NCH * NTAP - 1)),
                        16'($urandom)));
            end else begin
                repeat (NCH)
                    stimulus.push_back(sample_item(
                        ($urandom_range(0, 7) == 0) ? -16'sd32768 : 16'($urandom)));
            end
        end
    endtask

    // Sender: bursts of random length with random gaps.
    task automatic drive_items();
        int burst;
        while (stimulus.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && stimulus.size() > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b1;
                i_item <= stimulus[0];
                @(posedge i_clk);
                while (o_stall) @(posedge i_clk);
                sb.note_input(stimulus.pop_front());
                burst--;
            end
            @(negedge i_clk);
            i_valid <= 1'b0;
            i_item <= '0;
            if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
        stimulus_done = 1'b1;
    endtask

    // Receiver stall pattern: randomly chosen calm and busy phases, plus a
    // long hold-off requested by the pressure process.
    initial begin
        int mode;
        i_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 60)) begin
                @(negedge i_clk);
                if (hold_output) i_stall <= 1'b1;
                else if (mode == 0) i_stall <= 1'b0;
                else if (mode == 1) i_stall <= ($urandom_range(0, 3) == 0);
                else i_stall <= ($urandom_range(0, 1) == 0);
            end
        end
    end

    // Long hold-off half way through the items, so that the block fills up
    // and stalls its input while the sender keeps offering.
    initial begin
        hold_output = 1'b0;
        wait (i_rst_n);
        while (stimulus.size() >= 75) @(posedge i_clk);
        hold_output = 1'b1;
        repeat (4 * BLOCK_CYCLES) @(posedge i_clk);
        hold_output = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_item);
    end

    initial begin
        int waited;
        sb = new();
        stimulus_done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        build_stimulus();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // The clearing pass shows as o_stall; the sender waits on it.
        drive_items();
        waited = 0;
        while (sb.pending.size() > 0 && waited < 100 * BLOCK_CYCLES) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (BLOCK_CYCLES) @(posedge i_clk);
        $display("Covered %0d coefficient writes and %0d blocks (%0d magnitudes checked).",
                 sb.coef_writes, sb.blocks_seen, sb.results_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
            $display("Verification failed");
        end
        $finish;
    end
endmodule
